// File: rtl/sha2tr_pkg.sv
package sha2tr_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned HalfW   = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 1;
  // register stages from input to output
  localparam int unsigned NStage  = 6;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWideWords  = 2'd0,
    CfgUseLowPair = 2'd1
  } cfg_idx_e;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    word_t var_a;
    word_t var_b;
    word_t var_c;
    word_t var_d;
    word_t var_e;
    word_t var_f;
    word_t var_g;
    word_t var_h;
    word_t msg_word_0;
    word_t msg_word_1;
    word_t msg_word_2;
    word_t msg_word_3;
  } in_item_t;

  typedef struct packed {
    word_t new_a;
    word_t new_b;
    word_t new_e;
    word_t new_f;
  } out_item_t;

  // keep the low half only in narrow mode
  function automatic word_t fit(input word_t x, input logic wide);
    return wide ? x : {{(WordW-HalfW){1'b0}}, x[HalfW-1:0]};
  endfunction

  function automatic logic [HalfW-1:0] ror32(input logic [HalfW-1:0] x, input int unsigned n);
    return (x >> n) | (x << (HalfW - n));
  endfunction

  function automatic word_t ror64(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x, input logic wide);
    logic [HalfW-1:0] s;
    s = ror32(x[HalfW-1:0], 2) ^ ror32(x[HalfW-1:0], 13) ^ ror32(x[HalfW-1:0], 22);
    return wide ? (ror64(x, 28) ^ ror64(x, 34) ^ ror64(x, 39))
                : {{(WordW-HalfW){1'b0}}, s};
  endfunction

  function automatic word_t big_sigma1(input word_t x, input logic wide);
    logic [HalfW-1:0] s;
    s = ror32(x[HalfW-1:0], 6) ^ ror32(x[HalfW-1:0], 11) ^ ror32(x[HalfW-1:0], 25);
    return wide ? (ror64(x, 14) ^ ror64(x, 18) ^ ror64(x, 41))
                : {{(WordW-HalfW){1'b0}}, s};
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t major(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// File: rtl/sha2tr_in_if.sv
interface sha2tr_in_if;
  logic                 valid;
  logic                 ready;
  sha2tr_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/sha2tr_out_if.sv
interface sha2tr_out_if;
  logic                  valid;
  logic                  ready;
  sha2tr_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/sha2_two_round_compression_top.sv
// Two SHA-2 compression rounds per item (SHA-256 on 32-bit words or SHA-512 on
// 64-bit words, set by wide_words; use_low_pair picks message words 0/1 or 2/3).
// The block takes one item every cycle while the pipeline is not stalled and
// returns its new a, b, e and f from a six-stage pipeline (sigma/choose/major,
// then t1/t2, then new a/e, for each of the two rounds). The whole pipeline
// holds while the output stage is full and not taken. Configuration is to be
// written only while the pipeline is empty; the block itself does not enforce it.
module sha2_two_round_compression_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  sha2tr_in_if.sink                           in_i,
  sha2tr_out_if.source                        out_o,
  input  logic                                cfg_we_i,
  input  logic [sha2tr_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [sha2tr_pkg::CfgDatW-1:0]      cfg_data_i
);

  logic wide_q, low_pair_q;
  logic [sha2tr_pkg::NStage-1:0] vld_q, vld_d;
  logic en;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q     <= 1'b0;
      low_pair_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (sha2tr_pkg::cfg_idx_e'(cfg_idx_i))
        sha2tr_pkg::CfgWideWords:  wide_q     <= cfg_data_i[0];
        sha2tr_pkg::CfgUseLowPair: low_pair_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // global stall: the pipeline moves when the output stage can drain
  assign en        = !vld_q[sha2tr_pkg::NStage-1] || out_o.ready;
  assign in_i.ready = en;
  assign vld_d     = {vld_q[sha2tr_pkg::NStage-2:0], in_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // stage 1: mask inputs, round 1 sigma/choose/major, h+w and g+w
  sha2tr_pkg::word_t s1_a_q, s1_b_q, s1_c_q, s1_d_q, s1_e_q, s1_f_q;
  sha2tr_pkg::word_t s1_hw_q, s1_gw_q, s1_sg1_q, s1_ch_q, s1_sg0_q, s1_mj_q;
  logic s1_wide_q;
  sha2tr_pkg::word_t s1_a_d, s1_b_d, s1_c_d, s1_d_d, s1_e_d, s1_f_d, s1_g, s1_h, s1_w0, s1_w1;

  always_comb begin
    s1_a_d = sha2tr_pkg::fit(in_i.data.var_a, wide_q);
    s1_b_d = sha2tr_pkg::fit(in_i.data.var_b, wide_q);
    s1_c_d = sha2tr_pkg::fit(in_i.data.var_c, wide_q);
    s1_d_d = sha2tr_pkg::fit(in_i.data.var_d, wide_q);
    s1_e_d = sha2tr_pkg::fit(in_i.data.var_e, wide_q);
    s1_f_d = sha2tr_pkg::fit(in_i.data.var_f, wide_q);
    s1_g   = sha2tr_pkg::fit(in_i.data.var_g, wide_q);
    s1_h   = sha2tr_pkg::fit(in_i.data.var_h, wide_q);
    s1_w0  = sha2tr_pkg::fit(low_pair_q ? in_i.data.msg_word_0 : in_i.data.msg_word_2, wide_q);
    s1_w1  = sha2tr_pkg::fit(low_pair_q ? in_i.data.msg_word_1 : in_i.data.msg_word_3, wide_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_wide_q <= wide_q;
      s1_a_q    <= s1_a_d;
      s1_b_q    <= s1_b_d;
      s1_c_q    <= s1_c_d;
      s1_d_q    <= s1_d_d;
      s1_e_q    <= s1_e_d;
      s1_f_q    <= s1_f_d;
      s1_hw_q   <= sha2tr_pkg::fit(s1_h + s1_w0, wide_q);
      s1_gw_q   <= sha2tr_pkg::fit(s1_g + s1_w1, wide_q);
      s1_sg1_q  <= sha2tr_pkg::big_sigma1(s1_e_d, wide_q);
      s1_ch_q   <= sha2tr_pkg::choose(s1_e_d, s1_f_d, s1_g);
      s1_sg0_q  <= sha2tr_pkg::big_sigma0(s1_a_d, wide_q);
      s1_mj_q   <= sha2tr_pkg::major(s1_a_d, s1_b_d, s1_c_d);
    end
  end

  // stage 2: round 1 t1 and t2
  sha2tr_pkg::word_t s2_a_q, s2_b_q, s2_c_q, s2_d_q, s2_e_q, s2_f_q, s2_gw_q;
  sha2tr_pkg::word_t s2_t1_q, s2_t2_q;
  logic s2_wide_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_wide_q <= s1_wide_q;
      s2_a_q    <= s1_a_q;
      s2_b_q    <= s1_b_q;
      s2_c_q    <= s1_c_q;
      s2_d_q    <= s1_d_q;
      s2_e_q    <= s1_e_q;
      s2_f_q    <= s1_f_q;
      s2_gw_q   <= s1_gw_q;
      s2_t1_q   <= sha2tr_pkg::fit(s1_hw_q + s1_sg1_q + s1_ch_q, s1_wide_q);
      s2_t2_q   <= sha2tr_pkg::fit(s1_sg0_q + s1_mj_q, s1_wide_q);
    end
  end

  // stage 3: round 1 new a and e
  sha2tr_pkg::word_t s3_a_q, s3_b_q, s3_c_q, s3_e_q, s3_f_q, s3_gw_q, s3_a1_q, s3_e1_q;
  logic s3_wide_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_wide_q <= s2_wide_q;
      s3_a_q    <= s2_a_q;
      s3_b_q    <= s2_b_q;
      s3_c_q    <= s2_c_q;
      s3_e_q    <= s2_e_q;
      s3_f_q    <= s2_f_q;
      s3_gw_q   <= s2_gw_q;
      s3_a1_q   <= sha2tr_pkg::fit(s2_t1_q + s2_t2_q, s2_wide_q);
      s3_e1_q   <= sha2tr_pkg::fit(s2_d_q + s2_t1_q, s2_wide_q);
    end
  end

  // stage 4: round 2 sigma/choose/major; old a, b, e, f shift into b, c, f, g
  sha2tr_pkg::word_t s4_c_q, s4_gw_q, s4_a1_q, s4_e1_q;
  sha2tr_pkg::word_t s4_sg1_q, s4_ch_q, s4_sg0_q, s4_mj_q;
  logic s4_wide_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_wide_q <= s3_wide_q;
      s4_c_q    <= s3_c_q;
      s4_gw_q   <= s3_gw_q;
      s4_a1_q   <= s3_a1_q;
      s4_e1_q   <= s3_e1_q;
      s4_sg1_q  <= sha2tr_pkg::big_sigma1(s3_e1_q, s3_wide_q);
      s4_ch_q   <= sha2tr_pkg::choose(s3_e1_q, s3_e_q, s3_f_q);
      s4_sg0_q  <= sha2tr_pkg::big_sigma0(s3_a1_q, s3_wide_q);
      s4_mj_q   <= sha2tr_pkg::major(s3_a1_q, s3_a_q, s3_b_q);
    end
  end

  // stage 5: round 2 t1 and t2
  sha2tr_pkg::word_t s5_c_q, s5_a1_q, s5_e1_q, s5_t1_q, s5_t2_q;
  logic s5_wide_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_wide_q <= s4_wide_q;
      s5_c_q    <= s4_c_q;
      s5_a1_q   <= s4_a1_q;
      s5_e1_q   <= s4_e1_q;
      s5_t1_q   <= sha2tr_pkg::fit(s4_gw_q + s4_sg1_q + s4_ch_q, s4_wide_q);
      s5_t2_q   <= sha2tr_pkg::fit(s4_sg0_q + s4_mj_q, s4_wide_q);
    end
  end

  // stage 6: round 2 new a and e, output register
  sha2tr_pkg::out_item_t out_q;
  logic out_wide_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_wide_q  <= s5_wide_q;
      out_q.new_a <= sha2tr_pkg::fit(s5_t1_q + s5_t2_q, s5_wide_q);
      out_q.new_b <= s5_a1_q;
      // round 2 d is the original c
      out_q.new_e <= sha2tr_pkg::fit(s5_c_q + s5_t1_q, s5_wide_q);
      out_q.new_f <= s5_e1_q;
    end
  end

  assign out_o.valid = vld_q[sha2tr_pkg::NStage-1];
  assign out_o.data  = out_q;

  // narrow mode results are zero-extended
  a_narrow_zext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_wide_q |->
      out_o.data.new_a[63:32] == '0 && out_o.data.new_b[63:32] == '0 &&
      out_o.data.new_e[63:32] == '0 && out_o.data.new_f[63:32] == '0)
    else $error("narrow result has upper bits set");

  // an accepted item reaches stage 1
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> vld_q[0])
    else $error("accepted item lost at pipeline entry");

  // a stalled pipeline keeps all its valid bits
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid bits moved during stall");

  // a waiting result blocks new input
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input accepted while output stalled");

  // an item in the last inner stage reaches the output when moving
  a_reach_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[sha2tr_pkg::NStage-2] |=> out_o.valid)
    else $error("item lost before output stage");

endmodule
